@@ hw/rtl/lmps_pkg.sv @@
// Shared types and constants for the LED matrix PWM scanner.
package lmps_pkg;

	localparam int ROWS         = 8;
	localparam int COLUMNS      = 8;
	localparam int MAX_PWM_BITS = 6;

	localparam int ROW_W    = 3;
	localparam int COL_W    = 3;
	localparam int BRIGHT_W = 7;
	localparam int SLOT_W   = 6;
	localparam int PWM_W    = 3;
	localparam int SLOTS_W  = 7;

	localparam logic [PWM_W-1:0] PWM_BITS_RESET = 3'd6;
	localparam logic [PWM_W-1:0] PWM_BITS_MIN   = 3'd1;
	localparam logic [PWM_W-1:0] PWM_BITS_MAX   = PWM_W'(MAX_PWM_BITS);

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                 operation;
		logic [ROW_W-1:0]    pixel_row;
		logic [COL_W-1:0]    pixel_column;
		logic [BRIGHT_W-1:0] brightness;
	} cmd_t;

	typedef struct packed {
		logic [COLUMNS-1:0] column_pattern;
		logic [ROWS-1:0]    row_select;
		logic [SLOT_W-1:0]  slot_index;
		logic               frame_end;
	} res_t;

endpackage

@@ hw/rtl/lmps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/led_matrix_pwm_scanner.sv @@
// LED matrix PWM scanner: 8x8 brightness store, row scan and slot compare.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): a write item stores one pixel
//   brightness and gives no result; a tick item gives exactly one res item
//   with the column pattern, one-hot row select, slot index and frame end.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): sets pwm_bits, the log2
//   of slots per row; 0 counts as 1 and values above 6 count as 6. cfg_ready
//   is always high; write it only while the block is idle.
//   A tick passes through a stage for the brightness RAM read and then a
//   stage for compare and output; res_stall can hold it between them.
//   Throughput: one item per cycle while the output is not held, set by the
//   RAM read port of the eight column banks, each read at the current row.
//   Reset: counters go to zero, pwm_bits to 6, and every pixel reads as zero
//   brightness until written (per-pixel written flags, no clearing pass).
//   When res_stall and res_valid are both high the output holds; the pipeline
//   stage behind it fills, and cmd_stall rises once both stages are full.
module led_matrix_pwm_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  lmps_pkg::cmd_t                 cmd,
	output logic                           res_valid,
	input  logic                           res_stall,
	output lmps_pkg::res_t                 res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lmps_pkg::PWM_W-1:0]     cfg_data
);

	localparam int ROWS     = lmps_pkg::ROWS;
	localparam int COLUMNS  = lmps_pkg::COLUMNS;
	localparam int BRIGHT_W = lmps_pkg::BRIGHT_W;
	localparam int SLOT_W   = lmps_pkg::SLOT_W;
	localparam int SLOTS_W  = lmps_pkg::SLOTS_W;
	localparam int ROW_W    = lmps_pkg::ROW_W;
	localparam int PWM_W    = lmps_pkg::PWM_W;

	logic [PWM_W-1:0]              pwm_bits_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [ROW_W-1:0]              row_q;
	logic [ROWS-1:0][COLUMNS-1:0]  written_q;

	logic                          valid_s1;
	logic [SLOT_W-1:0]             slot_s1;
	logic [ROW_W-1:0]              row_s1;
	logic [SLOTS_W-1:0]            slots_s1;
	logic                          frame_end_s1;
	logic [COLUMNS-1:0]            written_s1;
	logic [BRIGHT_W-1:0]           bright_s1 [COLUMNS];
	logic [BRIGHT_W-1:0]           level [COLUMNS];

	logic                          res_valid_q;
	lmps_pkg::res_t                res_q;

	logic                          cmd_acc;
	logic                          is_tick;
	logic                          is_write;
	logic                          s2_load;
	logic                          s1_free;
	logic [PWM_W-1:0]              pwm_eff;
	logic [SLOTS_W-1:0]            slots;
	logic                          last_slot;
	logic [COLUMNS-1:0]            pattern;

	assign cfg_ready = 1'b1;

	assign s2_load   = !res_valid_q || !res_stall;
	assign s1_free   = !valid_s1 || s2_load;
	assign cmd_stall = !s1_free;
	assign cmd_acc   = cmd_valid && s1_free;
	assign is_tick   = cmd_acc && (cmd.operation == lmps_pkg::OP_TICK);
	assign is_write  = cmd_acc && (cmd.operation == lmps_pkg::OP_WRITE);

	// Clamp pwm_bits into its legal range.
	always_comb begin
		if (pwm_bits_q < lmps_pkg::PWM_BITS_MIN) begin
			pwm_eff = lmps_pkg::PWM_BITS_MIN;
		end else if (pwm_bits_q > lmps_pkg::PWM_BITS_MAX) begin
			pwm_eff = lmps_pkg::PWM_BITS_MAX;
		end else begin
			pwm_eff = pwm_bits_q;
		end
	end

	assign slots     = SLOTS_W'(1) << pwm_eff;
	// A counter past the period after pwm_bits was lowered counts as the last slot.
	assign last_slot = {1'b0, slot_q} >= (slots - SLOTS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_bits_q <= lmps_pkg::PWM_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pwm_bits_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			row_q  <= '0;
		end else if (is_tick) begin
			if (last_slot) begin
				slot_q <= '0;
				row_q  <= row_q + ROW_W'(1);
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (is_write) begin
			written_q[cmd.pixel_row][cmd.pixel_column] <= 1'b1;
		end
	end

	// One bank per column, addressed by row, so a whole row is read together.
	for (genvar c = 0; c < COLUMNS; c++) begin : g_bank
		lmps_ram #(
			.WIDTH(BRIGHT_W),
			.DEPTH(ROWS)
		) u_bank (
			.clk  (clk),
			.we   (is_write && (cmd.pixel_column == lmps_pkg::COL_W'(c))),
			.waddr(cmd.pixel_row),
			.wdata(cmd.brightness),
			.re   (is_tick),
			.raddr(row_q),
			.rdata(bright_s1[c])
		);

		// An unwritten pixel has zero brightness.
		assign level[c] = written_s1[c] ? bright_s1[c] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			slot_s1      <= slot_q;
			row_s1       <= row_q;
			slots_s1     <= slots;
			frame_end_s1 <= last_slot && (row_q == ROW_W'(ROWS - 1));
			written_s1   <= written_q[row_q];
		end
	end

	// Column c is lit when brightness + slot reaches the slot count; column 0 is the MSB.
	always_comb begin
		pattern = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			if ((BRIGHT_W + 1)'(level[c]) + (BRIGHT_W + 1)'(slot_s1)
			    >= (BRIGHT_W + 1)'(slots_s1)) begin
				pattern[COLUMNS - 1 - c] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_load) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			res_q.column_pattern <= pattern;
			res_q.row_select     <= ROWS'(1) << row_s1;
			res_q.slot_index     <= slot_s1;
			res_q.frame_end      <= frame_end_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
